FILE: src/assert_macros.svh
// Assertion helpers for the deframer core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/rbad_pkg.sv
`timescale 1ns / 1ps

package rbad_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF  = 8;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ELEMENT_COUNT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BULK_LENGTH   = 8'd1;

    localparam logic [7:0] MAX_COUNT_RESET  = 8'hFF;
    localparam logic [31:0] MAX_LENGTH_RESET = 32'hFFFF_FFFF;

    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    typedef enum logic [3:0] {
        PH_STAR    = 4'd0,
        PH_CNT_DIG = 4'd1,
        PH_CNT_LF  = 4'd2,
        PH_DOLLAR  = 4'd3,
        PH_LEN_DIG = 4'd4,
        PH_LEN_LF  = 4'd5,
        PH_DATA    = 4'd6,
        PH_DATA_CR = 4'd7,
        PH_DATA_LF = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_METHOD = 2'd0,
        ROLE_PATH   = 2'd1,
        ROLE_BODY   = 2'd2
    } t_role;

    typedef enum logic [1:0] {
        STATUS_BUSY  = 2'd0,
        STATUS_DONE  = 2'd1,
        STATUS_ERROR = 2'd2
    } t_status;

endpackage

FILE: src/resp_bulk_array_deframer_core.sv
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// input     i_in_valid / o_in_ready   i_data_byte
// output    o_out_valid / i_out_ready o_payload_valid, o_payload_byte,
//                                     o_element_role, o_element_end, o_status
// config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte is accepted per cycle unless the output stalls; its word is registered.
// The parse state advances as a byte moves from the input register to the result register.
// The configuration port is always ready and a write takes effect at once.
// Reset is synchronous; it clears the parse state and the error and sets both limits to maximum.
// A stalled output holds both registers and the input ready falls only when both are full.

`include "assert_macros.svh"

module resp_bulk_array_deframer_core #(
    parameter int LENGTH_BITS = rbad_pkg::LENGTH_BITS_DEF,
    parameter int COUNT_BITS  = rbad_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_data_byte,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_payload_valid,
    output logic [7:0]                        o_payload_byte,
    output logic [1:0]                        o_element_role,
    output logic                              o_element_end,
    output logic [1:0]                        o_status,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rbad_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [rbad_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int ACC_W  = (LENGTH_BITS > COUNT_BITS) ? LENGTH_BITS : COUNT_BITS;
    localparam int PROD_W = ACC_W + 4;
    localparam logic [ACC_W-1:0] COUNT_CAP = ACC_W'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [31:0] LENGTH_CAP = 32'((64'd1 << LENGTH_BITS) - 64'd1);

    logic [7:0]             r_max_count;
    logic [31:0]            r_max_length;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;

    logic                   r_out_valid;
    logic                   r_payload_valid;
    logic [7:0]             r_payload_byte;
    logic [1:0]             r_element_role;
    logic                   r_element_end;
    logic [1:0]             r_status;

    rbad_pkg::t_phase       r_phase, n_phase;
    logic [COUNT_BITS-1:0]  r_elem_left, n_elem_left;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic                   r_digit_seen, n_digit_seen;
    logic [LENGTH_BITS-1:0] r_data_left, n_data_left;
    logic [1:0]             r_elem_num, n_elem_num;
    logic                   r_error, n_error;

    logic                   advance;
    logic                   step;
    logic                   fault;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [PROD_W-1:0]      prod;
    logic [ACC_W-1:0]       count_lim;
    logic [31:0]            length_lim32;
    logic [ACC_W-1:0]       length_lim;
    logic [ACC_W-1:0]       lim;
    logic [LENGTH_BITS-1:0] data_left_dec;
    logic [COUNT_BITS-1:0]  elem_left_dec;

    logic                   n_payload_valid;
    logic [7:0]             n_payload_byte;
    logic [1:0]             n_element_role;
    logic                   n_element_end;
    logic [1:0]             n_status;

    assign advance     = !r_out_valid || i_out_ready;
    assign step        = advance && r_in_valid;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid     = r_out_valid;
    assign o_payload_valid = r_payload_valid;
    assign o_payload_byte  = r_payload_byte;
    assign o_element_role  = r_element_role;
    assign o_element_end   = r_element_end;
    assign o_status        = r_status;

    assign is_digit = (r_in_byte >= rbad_pkg::CHAR_ZERO) && (r_in_byte <= rbad_pkg::CHAR_NINE);
    assign digit    = 4'(r_in_byte - rbad_pkg::CHAR_ZERO);
    assign prod     = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + {{ACC_W{1'b0}}, digit};

    assign count_lim    = ({{(ACC_W-8){1'b0}}, r_max_count} < COUNT_CAP)
                        ? {{(ACC_W-8){1'b0}}, r_max_count} : COUNT_CAP;
    assign length_lim32 = (r_max_length < LENGTH_CAP) ? r_max_length : LENGTH_CAP;
    assign length_lim   = ACC_W'(length_lim32);
    assign lim          = (r_phase == rbad_pkg::PH_CNT_DIG) ? count_lim : length_lim;

    assign data_left_dec = r_data_left - LENGTH_BITS'(1);
    assign elem_left_dec = r_elem_left - COUNT_BITS'(1);

    // Next parse state for the byte in the input register.
    always_comb begin
        n_phase      = r_phase;
        n_elem_left  = r_elem_left;
        n_acc        = r_acc;
        n_digit_seen = r_digit_seen;
        n_data_left  = r_data_left;
        n_elem_num   = r_elem_num;
        fault        = 1'b0;
        if (!r_error) begin
            case (r_phase)
                rbad_pkg::PH_STAR, rbad_pkg::PH_DOLLAR: begin
                    if ((r_phase == rbad_pkg::PH_STAR && r_in_byte == rbad_pkg::CHAR_STAR) ||
                        (r_phase == rbad_pkg::PH_DOLLAR &&
                         r_in_byte == rbad_pkg::CHAR_DOLLAR)) begin
                        n_acc        = '0;
                        n_digit_seen = 1'b0;
                        n_phase      = (r_phase == rbad_pkg::PH_STAR) ? rbad_pkg::PH_CNT_DIG
                                                                      : rbad_pkg::PH_LEN_DIG;
                    end else begin
                        fault = 1'b1;
                    end
                end
                rbad_pkg::PH_CNT_DIG, rbad_pkg::PH_LEN_DIG: begin
                    if (is_digit) begin
                        if (prod > {4'b0000, lim}) begin
                            fault = 1'b1;
                        end else begin
                            n_acc        = ACC_W'(prod);
                            n_digit_seen = 1'b1;
                        end
                    end else if (r_in_byte == rbad_pkg::CHAR_CR && r_digit_seen) begin
                        n_phase = (r_phase == rbad_pkg::PH_CNT_DIG) ? rbad_pkg::PH_CNT_LF
                                                                    : rbad_pkg::PH_LEN_LF;
                    end else begin
                        fault = 1'b1;
                    end
                end
                rbad_pkg::PH_CNT_LF: begin
                    if (r_in_byte != rbad_pkg::CHAR_LF || r_acc == '0) begin
                        fault = 1'b1;
                    end else begin
                        n_elem_left = COUNT_BITS'(r_acc);
                        n_elem_num  = rbad_pkg::ROLE_METHOD;
                        n_phase     = rbad_pkg::PH_DOLLAR;
                    end
                end
                rbad_pkg::PH_LEN_LF: begin
                    if (r_in_byte != rbad_pkg::CHAR_LF) begin
                        fault = 1'b1;
                    end else begin
                        n_data_left = LENGTH_BITS'(r_acc);
                        n_phase     = (r_acc != '0) ? rbad_pkg::PH_DATA : rbad_pkg::PH_DATA_CR;
                    end
                end
                rbad_pkg::PH_DATA: begin
                    n_data_left = data_left_dec;
                    if (data_left_dec == '0) begin
                        n_phase = rbad_pkg::PH_DATA_CR;
                    end
                end
                rbad_pkg::PH_DATA_CR: begin
                    if (r_in_byte == rbad_pkg::CHAR_CR) begin
                        n_phase = rbad_pkg::PH_DATA_LF;
                    end else begin
                        fault = 1'b1;
                    end
                end
                rbad_pkg::PH_DATA_LF: begin
                    if (r_in_byte != rbad_pkg::CHAR_LF) begin
                        fault = 1'b1;
                    end else begin
                        if (r_elem_num != rbad_pkg::ROLE_BODY) begin
                            n_elem_num = r_elem_num + 2'd1;
                        end
                        n_elem_left = elem_left_dec;
                        n_phase     = (elem_left_dec == '0) ? rbad_pkg::PH_STAR
                                                            : rbad_pkg::PH_DOLLAR;
                    end
                end
                default: begin
                    fault = 1'b1;
                end
            endcase
        end
        n_error = r_error || fault;
    end

    // Result word for the byte in the input register.
    always_comb begin
        n_payload_valid = 1'b0;
        n_payload_byte  = 8'h00;
        n_element_role  = rbad_pkg::ROLE_METHOD;
        n_element_end   = 1'b0;
        n_status        = rbad_pkg::STATUS_BUSY;
        if (n_error) begin
            n_status = rbad_pkg::STATUS_ERROR;
        end else begin
            case (r_phase)
                rbad_pkg::PH_DATA: begin
                    n_payload_valid = 1'b1;
                    n_payload_byte  = r_in_byte;
                    n_element_role  = r_elem_num;
                end
                rbad_pkg::PH_DATA_LF: begin
                    n_element_end  = 1'b1;
                    n_element_role = r_elem_num;
                    if (elem_left_dec == '0) begin
                        n_status = rbad_pkg::STATUS_DONE;
                    end
                end
                default: begin
                    n_status = rbad_pkg::STATUS_BUSY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_count  <= rbad_pkg::MAX_COUNT_RESET;
            r_max_length <= rbad_pkg::MAX_LENGTH_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == rbad_pkg::CFG_MAX_ELEMENT_COUNT) begin
                r_max_count <= i_cfg_data[7:0];
            end else if (i_cfg_index == rbad_pkg::CFG_MAX_BULK_LENGTH) begin
                r_max_length <= i_cfg_data[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= rbad_pkg::PH_STAR;
            r_elem_left  <= '0;
            r_acc        <= '0;
            r_digit_seen <= 1'b0;
            r_data_left  <= '0;
            r_elem_num   <= rbad_pkg::ROLE_METHOD;
            r_error      <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_phase      <= n_phase;
                r_elem_left  <= n_elem_left;
                r_acc        <= n_acc;
                r_digit_seen <= n_digit_seen;
                r_data_left  <= n_data_left;
                r_elem_num   <= n_elem_num;
                r_error      <= n_error;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
        end
        if (step) begin
            r_payload_valid <= n_payload_valid;
            r_payload_byte  <= n_payload_byte;
            r_element_role  <= n_element_role;
            r_element_end   <= n_element_end;
            r_status        <= n_status;
        end
    end

    `ASSERT_CLK(a_error_sticky, i_clk, i_rst_n, r_error |=> r_error,
                "Error flag cleared without reset")
    `ASSERT_CLK(a_error_word, i_clk, i_rst_n,
                (step && r_error) |=> (o_status == rbad_pkg::STATUS_ERROR),
                "Word after error is not flagged")
    `ASSERT_NEVER(a_error_quiet, i_clk, i_rst_n,
                  r_out_valid && r_status == rbad_pkg::STATUS_ERROR &&
                  (r_payload_valid || r_element_end),
                  "Error word carries data")
    `ASSERT_NEVER(a_done_on_end, i_clk, i_rst_n,
                  r_out_valid && r_status == rbad_pkg::STATUS_DONE && !r_element_end,
                  "Request complete away from an element end")

endmodule

FILE: verif/resp_bulk_array_deframer_core_tb.sv
`timescale 1ns / 1ps

module resp_bulk_array_deframer_core_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 150;
    localparam int FAULT_KINDS = 13;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic       pvalid;
        logic [7:0] pbyte;
        logic [1:0] role;
        logic       eend;
        logic [1:0] status;
    } t_word;

    typedef enum int {
        FAULT_ARRAY_MARKER,
        FAULT_BULK_MARKER,
        FAULT_COUNT_DIGIT,
        FAULT_EMPTY_COUNT,
        FAULT_COUNT_LIMIT,
        FAULT_ZERO_COUNT,
        FAULT_COUNT_LF,
        FAULT_LENGTH_DIGIT,
        FAULT_EMPTY_LENGTH,
        FAULT_LENGTH_LIMIT,
        FAULT_LENGTH_LF,
        FAULT_DATA_CR,
        FAULT_DATA_LF
    } t_fault;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic [7:0] i_data_byte;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_payload_valid;
    logic [7:0] o_payload_byte;
    logic [1:0] o_element_role;
    logic o_element_end;
    logic [1:0] o_status;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [rbad_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [rbad_pkg::CFG_DATA_W-1:0] i_cfg_data;

    rbad_pkg::t_phase phase = rbad_pkg::PH_STAR;
    logic [7:0] elems_left = '0;
    logic [31:0] num_value = '0;
    logic have_digit = 1'b0;
    logic [31:0] bytes_left = '0;
    logic [1:0] elem_role = rbad_pkg::ROLE_METHOD;
    logic fault_seen = 1'b0;
    logic [7:0] lim_count = rbad_pkg::MAX_COUNT_RESET;
    logic [31:0] lim_len = rbad_pkg::MAX_LENGTH_RESET;

    t_word expected_words[$];
    int mismatches = 0;
    int bytes_sent = 0;
    int cycle_count = 0;
    bit calm = 1'b0;

    resp_bulk_array_deframer_core u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_data_byte(i_data_byte),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_payload_valid(o_payload_valid),
        .o_payload_byte(o_payload_byte),
        .o_element_role(o_element_role),
        .o_element_end(o_element_end),
        .o_status(o_status),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic number_step(input logic [7:0] b, input logic [31:0] limit,
                                         input rbad_pkg::t_phase next_phase);
        logic [63:0] grown;
        if (b >= rbad_pkg::CHAR_ZERO && b <= rbad_pkg::CHAR_NINE) begin
            grown = 64'(num_value) * 64'd10 + 64'(b - rbad_pkg::CHAR_ZERO);
            if (grown > 64'(limit)) begin
                return 1'b0;
            end
            num_value = grown[31:0];
            have_digit = 1'b1;
            return 1'b1;
        end
        if (b == rbad_pkg::CHAR_CR && have_digit) begin
            phase = next_phase;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        t_word want;
        logic ok;
        want = '0;
        ok = 1'b1;
        if (!fault_seen) begin
            case (phase)
                rbad_pkg::PH_STAR: begin
                    if (b == rbad_pkg::CHAR_STAR) begin
                        num_value = '0;
                        have_digit = 1'b0;
                        phase = rbad_pkg::PH_CNT_DIG;
                    end else begin
                        ok = 1'b0;
                    end
                end
                rbad_pkg::PH_CNT_DIG: begin
                    ok = number_step(b, {24'd0, lim_count}, rbad_pkg::PH_CNT_LF);
                end
                rbad_pkg::PH_CNT_LF: begin
                    if (b != rbad_pkg::CHAR_LF || num_value == 0) begin
                        ok = 1'b0;
                    end else begin
                        elems_left = num_value[7:0];
                        elem_role = rbad_pkg::ROLE_METHOD;
                        phase = rbad_pkg::PH_DOLLAR;
                    end
                end
                rbad_pkg::PH_DOLLAR: begin
                    if (b == rbad_pkg::CHAR_DOLLAR) begin
                        num_value = '0;
                        have_digit = 1'b0;
                        phase = rbad_pkg::PH_LEN_DIG;
                    end else begin
                        ok = 1'b0;
                    end
                end
                rbad_pkg::PH_LEN_DIG: ok = number_step(b, lim_len, rbad_pkg::PH_LEN_LF);
                rbad_pkg::PH_LEN_LF: begin
                    if (b != rbad_pkg::CHAR_LF) begin
                        ok = 1'b0;
                    end else begin
                        bytes_left = num_value;
                        if (num_value != 0) begin
                            phase = rbad_pkg::PH_DATA;
                        end else begin
                            phase = rbad_pkg::PH_DATA_CR;
                        end
                    end
                end
                rbad_pkg::PH_DATA: begin
                    want.pvalid = 1'b1;
                    want.pbyte = b;
                    want.role = elem_role;
                    bytes_left = bytes_left - 32'd1;
                    if (bytes_left == 0) begin
                        phase = rbad_pkg::PH_DATA_CR;
                    end
                end
                rbad_pkg::PH_DATA_CR: begin
                    if (b == rbad_pkg::CHAR_CR) begin
                        phase = rbad_pkg::PH_DATA_LF;
                    end else begin
                        ok = 1'b0;
                    end
                end
                rbad_pkg::PH_DATA_LF: begin
                    if (b != rbad_pkg::CHAR_LF) begin
                        ok = 1'b0;
                    end else begin
                        want.eend = 1'b1;
                        want.role = elem_role;
                        if (elem_role != rbad_pkg::ROLE_BODY) begin
                            elem_role = elem_role + 2'd1;
                        end
                        elems_left = elems_left - 8'd1;
                        if (elems_left == 0) begin
                            want.status = rbad_pkg::STATUS_DONE;
                            phase = rbad_pkg::PH_STAR;
                        end else begin
                            phase = rbad_pkg::PH_DOLLAR;
                        end
                    end
                end
                default: ok = 1'b0;
            endcase
            if (!ok) begin
                fault_seen = 1'b1;
            end
        end
        if (fault_seen) begin
            want = '0;
            want.status = rbad_pkg::STATUS_ERROR;
        end
        expected_words.push_back(want);
    endfunction

    function automatic logic [7:0] random_byte_except(input logic [7:0] avoid,
                                                      input bit avoid_digits);
        logic [7:0] b;
        do begin
            b = 8'($urandom());
        end while (b == avoid || (avoid_digits && b >= rbad_pkg::CHAR_ZERO &&
                                  b <= rbad_pkg::CHAR_NINE));
        return b;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        deframe_byte(b);
    endtask

    task automatic send_crlf();
        send_byte(rbad_pkg::CHAR_CR);
        send_byte(rbad_pkg::CHAR_LF);
    endtask

    task automatic send_number(input longint unsigned v, input int pad);
        logic [7:0] digits[$];
        digits = {};
        do begin
            digits.push_front(rbad_pkg::CHAR_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        repeat (pad) send_byte(rbad_pkg::CHAR_ZERO);
        foreach (digits[i]) begin
            send_byte(digits[i]);
        end
    endtask

    task automatic open_array(input int n_elems);
        send_byte(rbad_pkg::CHAR_STAR);
        send_number(n_elems, 0);
        send_crlf();
    endtask

    task automatic send_bulk(input logic [7:0] data[$], input int pad);
        send_byte(rbad_pkg::CHAR_DOLLAR);
        send_number(data.size(), pad);
        send_crlf();
        foreach (data[i]) begin
            send_byte(data[i]);
        end
        send_crlf();
    endtask

    task automatic send_non_digit();
        if ($urandom_range(2) == 0) begin
            send_byte(CHAR_MINUS);
            send_byte(rbad_pkg::CHAR_ZERO + 8'd1);
        end else begin
            send_byte(random_byte_except(rbad_pkg::CHAR_CR, 1'b1));
        end
    endtask

    task automatic send_frame();
        int cap;
        int len_cap;
        int n_elems;
        int len;
        logic [7:0] data[$];
        cap = (lim_count < 5) ? int'(lim_count) : 5;
        if ($urandom_range(7) == 0) begin
            cap = (lim_count < 24) ? int'(lim_count) : 24;
        end
        if (lim_count <= 12 && $urandom_range(3) == 0) begin
            n_elems = int'(lim_count);
        end else begin
            n_elems = $urandom_range(1, cap);
        end
        send_byte(rbad_pkg::CHAR_STAR);
        send_number(n_elems, ($urandom_range(9) == 0) ? 1 : 0);
        send_crlf();
        repeat (n_elems) begin
            len_cap = (lim_len < 6) ? int'(lim_len) : 6;
            if ($urandom_range(9) == 0) begin
                len_cap = (lim_len < 40) ? int'(lim_len) : 40;
            end
            if (lim_len <= 40 && $urandom_range(4) == 0) begin
                len = int'(lim_len);
            end else begin
                len = $urandom_range(0, len_cap);
            end
            data = {};
            repeat (len) begin
                case ($urandom_range(7))
                    0: data.push_back(rbad_pkg::CHAR_STAR);
                    1: data.push_back(rbad_pkg::CHAR_DOLLAR);
                    2: data.push_back(rbad_pkg::CHAR_CR);
                    3: data.push_back(rbad_pkg::CHAR_LF);
                    default: data.push_back(8'($urandom()));
                endcase
            end
            send_bulk(data, ($urandom_range(9) == 0) ? 1 : 0);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    task automatic run_frames(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target) begin
            send_frame();
        end
        drain_results();
    endtask

    task automatic program_limits(input logic [7:0] count_lim, input logic [31:0] len_lim);
        logic [rbad_pkg::CFG_INDEX_W-1:0] idx[3];
        logic [rbad_pkg::CFG_DATA_W-1:0] val[3];
        idx[0] = rbad_pkg::CFG_MAX_ELEMENT_COUNT;
        val[0] = {24'($urandom()), count_lim};
        idx[1] = rbad_pkg::CFG_MAX_BULK_LENGTH;
        val[1] = len_lim;
        idx[2] = rbad_pkg::CFG_INDEX_W'($urandom_range(rbad_pkg::CFG_MAX_BULK_LENGTH + 1,
                                                       (1 << rbad_pkg::CFG_INDEX_W) - 1));
        val[2] = $urandom();
        foreach (idx[k]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            if (idx[k] == rbad_pkg::CFG_MAX_ELEMENT_COUNT) begin
                lim_count = val[k][7:0];
            end else if (idx[k] == rbad_pkg::CFG_MAX_BULK_LENGTH) begin
                lim_len = val[k];
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_frames();
        logic [7:0] data[$];
        open_array(3);
        data = {8'h00};
        send_bulk(data, 0);
        data = {8'hFF};
        send_bulk(data, 1);
        data = {};
        send_bulk(data, 0);
        send_byte(rbad_pkg::CHAR_STAR);
        send_number(1, 1);
        send_crlf();
        send_bulk(data, 0);
        drain_results();
    endtask

    task automatic test_default_limits();
        run_frames(PHASE_BYTES);
    endtask

    task automatic test_tightest_limits();
        program_limits(8'd1, 32'd0);
        calm = 1'b1;
        run_frames(PHASE_BYTES);
        calm = 1'b0;
    endtask

    task automatic test_widest_limits();
        program_limits(rbad_pkg::MAX_COUNT_RESET, rbad_pkg::MAX_LENGTH_RESET);
        run_frames(PHASE_BYTES);
    endtask

    task automatic test_single_element_limits();
        program_limits(8'd1, rbad_pkg::MAX_LENGTH_RESET);
        run_frames(PHASE_BYTES);
    endtask

    task automatic test_random_limits();
        program_limits(8'($urandom_range(2, 12)), $urandom_range(1, 40));
        run_frames(PHASE_BYTES);
        program_limits(8'($urandom_range(1, 255)), $urandom());
        run_frames(PHASE_BYTES);
    endtask

    // A fault can be raised only once per run, so one kind is chosen at random.
    task automatic test_sticky_error();
        t_fault fault;
        int len;
        fault = t_fault'($urandom_range(0, FAULT_KINDS - 1));
        send_frame();
        len = $urandom_range(0, (lim_len < 3) ? int'(lim_len) : 3);
        case (fault)
            FAULT_ARRAY_MARKER: send_byte(random_byte_except(rbad_pkg::CHAR_STAR, 1'b0));
            FAULT_BULK_MARKER: begin
                open_array(1);
                send_byte(random_byte_except(rbad_pkg::CHAR_DOLLAR, 1'b0));
            end
            FAULT_COUNT_DIGIT: begin
                send_byte(rbad_pkg::CHAR_STAR);
                if ($urandom_range(1) == 0) begin
                    send_byte(rbad_pkg::CHAR_ZERO + 8'd1);
                end
                send_non_digit();
            end
            FAULT_EMPTY_COUNT: begin
                send_byte(rbad_pkg::CHAR_STAR);
                send_byte(rbad_pkg::CHAR_CR);
            end
            FAULT_COUNT_LIMIT: begin
                send_byte(rbad_pkg::CHAR_STAR);
                send_number(64'(lim_count) + 1 + $urandom_range(0, 500), 0);
            end
            FAULT_ZERO_COUNT: begin
                send_byte(rbad_pkg::CHAR_STAR);
                send_number(0, $urandom_range(0, 1));
                send_crlf();
            end
            FAULT_COUNT_LF: begin
                send_byte(rbad_pkg::CHAR_STAR);
                send_number(1, 0);
                send_byte(rbad_pkg::CHAR_CR);
                send_byte(random_byte_except(rbad_pkg::CHAR_LF, 1'b0));
            end
            FAULT_LENGTH_DIGIT: begin
                open_array(1);
                send_byte(rbad_pkg::CHAR_DOLLAR);
                if ($urandom_range(1) == 0) begin
                    send_byte(rbad_pkg::CHAR_ZERO);
                end
                send_non_digit();
            end
            FAULT_EMPTY_LENGTH: begin
                open_array(1);
                send_byte(rbad_pkg::CHAR_DOLLAR);
                send_byte(rbad_pkg::CHAR_CR);
            end
            FAULT_LENGTH_LIMIT: begin
                open_array(1);
                send_byte(rbad_pkg::CHAR_DOLLAR);
                send_number(64'(lim_len) + 1 + $urandom_range(0, 1000), 0);
            end
            FAULT_LENGTH_LF: begin
                open_array(1);
                send_byte(rbad_pkg::CHAR_DOLLAR);
                send_number(0, 0);
                send_byte(rbad_pkg::CHAR_CR);
                send_byte(random_byte_except(rbad_pkg::CHAR_LF, 1'b0));
            end
            FAULT_DATA_CR, FAULT_DATA_LF: begin
                open_array(1);
                send_byte(rbad_pkg::CHAR_DOLLAR);
                send_number(len, 0);
                send_crlf();
                repeat (len) send_byte(8'($urandom()));
                if (fault == FAULT_DATA_CR) begin
                    send_byte(random_byte_except(rbad_pkg::CHAR_CR, 1'b0));
                end else begin
                    send_byte(rbad_pkg::CHAR_CR);
                    send_byte(random_byte_except(rbad_pkg::CHAR_LF, 1'b0));
                end
            end
            default: send_byte(random_byte_except(rbad_pkg::CHAR_STAR, 1'b0));
        endcase
        repeat (20) send_byte(8'($urandom()));
        send_frame();
        drain_results();
    endtask

    always @(posedge i_clk) begin : result_check
        t_word want;
        i_out_ready <= calm || ($urandom_range(99) >= 37);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $error("result word with no byte pending");
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                check_field("payload_valid", 8'(want.pvalid), 8'(o_payload_valid));
                check_field("payload_byte", want.pbyte, o_payload_byte);
                check_field("element_role", 8'(want.role), 8'(o_element_role));
                check_field("element_end", 8'(want.eend), 8'(o_element_end));
                check_field("status", 8'(want.status), 8'(o_status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_data_byte <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_frames();
        test_default_limits();
        test_tightest_limits();
        test_widest_limits();
        test_single_element_limits();
        test_random_limits();
        test_sticky_error();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
